[rtl/rgbcct_pkg.sv]
`default_nettype none

package rgbcct_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = FRAC_BITS + 3;   // three integer bits, |n| < 8
  localparam int N_W       = Q_W + 1;         // signed n
  localparam int XYZ_W     = 34;
  localparam int NUM_W     = 48;
  localparam int DV_W      = NUM_W + 2;
  localparam int REM_W     = NUM_W + 3;
  localparam int ACC_W     = 32;
  localparam int P_W       = ACC_W + N_W;
  localparam int FIN_W     = 40;
  localparam int NSTAGE    = Q_W + 14;

  localparam logic signed [15:0] MXR = -16'sd2340;
  localparam logic signed [15:0] MXG = 16'sd25383;
  localparam logic signed [15:0] MXB = -16'sd15670;
  localparam logic signed [15:0] MYR = -16'sd5319;
  localparam logic signed [15:0] MYG = 16'sd25860;
  localparam logic signed [15:0] MYB = -16'sd11992;
  localparam logic signed [15:0] MZR = -16'sd11174;
  localparam logic signed [15:0] MZG = 16'sd12628;
  localparam logic signed [15:0] MZB = 16'sd9229;
  localparam logic signed [15:0] K_0332  = 16'sd5439;
  localparam logic signed [15:0] K_01858 = 16'sd3044;

  localparam logic signed [ACC_W-1:0] CUB3 = 32'sd7356416;
  localparam logic signed [ACC_W-1:0] CUB2 = 32'sd57753600;
  localparam logic signed [ACC_W-1:0] CUB1 = 32'sd111792947;
  localparam logic signed [ACC_W-1:0] CUB0 = 32'sd90445087;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_CLAMP    = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] lux;
    logic        lux_clamp;
    logic        neg;
    logic        dz;
    logic        big;
  } side_t;

endpackage

`default_nettype wire

[rtl/rgb_color_temperature_and_lux.sv]
`default_nettype none

// RGB sample to correlated color temperature (McCamy) and lux.
// Input channel: in_red/in_green/in_blue with in_valid/in_ready; a request is
// taken when both are high. Result channel: out_cct_kelvin, out_lux,
// out_status with out_valid/out_ready.
// Throughput: one request per cycle while the pipeline is not stalled. The
// depth is set mostly by the restoring divider, one quotient bit per stage,
// plus matrix, numerator/denominator and three Horner multiply/add pairs.
// The whole pipeline advances together: when the receiver holds out_ready low
// with a result waiting, every stage holds and in_ready drops; nothing is
// lost or repeated. Empty slots move on while out_valid is low.
// Reset (rst_n low, synchronous) clears all valid bits; no result is shown
// until a new request has passed through.
// out_status: 0 valid, 1 zero denominator (cct 0), 2 cct or lux clamped.

module rgb_color_temperature_and_lux
  import rgbcct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_red,
  input  wire logic [15:0] in_green,
  input  wire logic [15:0] in_blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_cct_kelvin,
  output logic [15:0]      out_lux,
  output logic [1:0]       out_status
);

  logic en;
  logic [NSTAGE-1:0] vld_r, vld_nxt;

  assign en       = !vld_r[NSTAGE-1] || out_ready;
  assign in_ready = en;
  assign vld_nxt  = {vld_r[NSTAGE-2:0], in_valid};

  // stage 1: matrix products
  logic signed [32:0] p_r [9];
  logic signed [32:0] p_nxt [9];
  logic signed [16:0] ri, gi, bi;
  assign ri = $signed({1'b0, in_red});
  assign gi = $signed({1'b0, in_green});
  assign bi = $signed({1'b0, in_blue});

  always_comb begin
    p_nxt[0] = ri * MXR;
    p_nxt[1] = gi * MXG;
    p_nxt[2] = bi * MXB;
    p_nxt[3] = ri * MYR;
    p_nxt[4] = gi * MYG;
    p_nxt[5] = bi * MYB;
    p_nxt[6] = ri * MZR;
    p_nxt[7] = gi * MZG;
    p_nxt[8] = bi * MZB;
  end

  // stage 2: X, Y, Z
  logic signed [XYZ_W-1:0] x2_r, y2_r, z2_r, x2_nxt, y2_nxt, z2_nxt;
  assign x2_nxt = XYZ_W'(p_r[0]) + XYZ_W'(p_r[1]) + XYZ_W'(p_r[2]);
  assign y2_nxt = XYZ_W'(p_r[3]) + XYZ_W'(p_r[4]) + XYZ_W'(p_r[5]);
  assign z2_nxt = XYZ_W'(p_r[6]) + XYZ_W'(p_r[7]) + XYZ_W'(p_r[8]);

  // stage 3: S and lux
  logic signed [XYZ_W-1:0] s3_r, x3_r, y3_r, s3_nxt;
  logic [15:0]             lux3_r, lux3_nxt;
  logic                    lc3_r, lc3_nxt;
  logic [XYZ_W-1:0]        ymag;
  logic [XYZ_W-15:0]       yint;

  assign s3_nxt = x2_r + y2_r + z2_r;
  assign ymag   = y2_r[XYZ_W-1] ? XYZ_W'(-y2_r) : XYZ_W'(y2_r);
  assign yint   = ymag[XYZ_W-1:14];

  always_comb begin
    if (y2_r[XYZ_W-1]) begin
      lux3_nxt = 16'd0;
      lc3_nxt  = (yint != '0);
    end else if (yint > (XYZ_W-14)'(16'hFFFF)) begin
      lux3_nxt = 16'hFFFF;
      lc3_nxt  = 1'b1;
    end else begin
      lux3_nxt = yint[15:0];
      lc3_nxt  = 1'b0;
    end
  end

  // stage 4: numerator and denominator of n
  logic signed [NUM_W-1:0] num4_r, den4_r, num4_nxt, den4_nxt;
  logic [15:0]             lux4_r;
  logic                    lc4_r;
  assign num4_nxt = (NUM_W'(x3_r) <<< 14) - NUM_W'(s3_r) * NUM_W'(K_0332);
  assign den4_nxt = NUM_W'(s3_r) * NUM_W'(K_01858) - (NUM_W'(y3_r) <<< 14);

  // stage 5: magnitudes
  logic [NUM_W-1:0] an5_r, ad5_r, an5_nxt, ad5_nxt;
  side_t            sd5_r, sd5_nxt;
  assign an5_nxt = num4_r[NUM_W-1] ? NUM_W'(-num4_r) : NUM_W'(num4_r);
  assign ad5_nxt = den4_r[NUM_W-1] ? NUM_W'(-den4_r) : NUM_W'(den4_r);
  always_comb begin
    sd5_nxt.lux       = lux4_r;
    sd5_nxt.lux_clamp = lc4_r;
    sd5_nxt.neg       = num4_r[NUM_W-1] ^ den4_r[NUM_W-1];
    sd5_nxt.dz        = (den4_r == '0);
    sd5_nxt.big       = 1'b0;
  end

  // stage 6 and divider: rem_r[k], dv_r[k], q_r[k] feed quotient bit k
  logic [REM_W-1:0] rem_r [Q_W+1];
  logic [DV_W-1:0]  dv_r  [Q_W+1];
  logic [Q_W-1:0]   q_r   [Q_W+1];
  side_t            sdd_r [Q_W+1];
  side_t            sd6_nxt;

  always_comb begin
    sd6_nxt     = sd5_r;
    sd6_nxt.big = (REM_W'(an5_r) >= {ad5_r, 3'b000}) && (an5_r != '0);
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [REM_W:0]   diff;
    logic             qb;
    logic [REM_W-1:0] rsel;
    assign diff = {1'b0, rem_r[k]} - (REM_W+1)'(dv_r[k]);
    assign qb   = !diff[REM_W];
    assign rsel = qb ? diff[REM_W-1:0] : rem_r[k];
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= {rsel[REM_W-2:0], 1'b0};
        dv_r[k+1]  <= dv_r[k];
        q_r[k+1]   <= {q_r[k][Q_W-2:0], qb};
        sdd_r[k+1] <= sdd_r[k];
      end
    end
  end

  // signed n, then Horner steps
  logic signed [N_W-1:0]   n_r, nm1_r, na1_r, nm2_r, na2_r, n_nxt;
  side_t                   sdn_r, sdm1_r, sda1_r, sdm2_r, sda2_r, sdm3_r, sda3_r;
  logic signed [P_W-1:0]   pm1_r, pm2_r, pm3_r, pm1_nxt, pm2_nxt, pm3_nxt;
  logic signed [ACC_W-1:0] a1_r, a2_r, a1_nxt, a2_nxt;
  logic signed [FIN_W-1:0] a3_r, a3_nxt;
  logic signed [P_W-1:0]   sh1, sh2, sh3;

  assign n_nxt   = sdd_r[Q_W].neg ? -$signed({1'b0, q_r[Q_W]})
                                  : $signed({1'b0, q_r[Q_W]});
  assign pm1_nxt = P_W'(CUB3) * P_W'(n_r);
  assign sh1     = pm1_r >>> FRAC_BITS;
  assign a1_nxt  = ACC_W'(sh1) + CUB2;
  assign pm2_nxt = P_W'(a1_r) * P_W'(na1_r);
  assign sh2     = pm2_r >>> FRAC_BITS;
  assign a2_nxt  = ACC_W'(sh2) + CUB1;
  assign pm3_nxt = P_W'(a2_r) * P_W'(na2_r);
  assign sh3     = pm3_r >>> FRAC_BITS;
  assign a3_nxt  = FIN_W'(sh3) + FIN_W'(CUB0);

  // final clamp and status
  logic signed [FIN_W-15:0] cint;
  logic [15:0]              cct_nxt, cct_r, lux_r;
  status_t                  st_nxt, st_r;
  logic                     cclamp;

  // upper bits are the floor of a3 / 2^14
  assign cint = a3_r[FIN_W-1:14];

  always_comb begin
    cct_nxt = 16'd0;
    cclamp  = 1'b0;
    if (sda3_r.dz) begin
      cct_nxt = 16'd0;
    end else if (sda3_r.big) begin
      cct_nxt = sda3_r.neg ? 16'd0 : 16'hFFFF;
      cclamp  = 1'b1;
    end else if (cint[FIN_W-15]) begin
      cct_nxt = 16'd0;
      cclamp  = 1'b1;
    end else if (cint > (FIN_W-14)'(17'sh0FFFF)) begin
      cct_nxt = 16'hFFFF;
      cclamp  = 1'b1;
    end else begin
      cct_nxt = cint[15:0];
    end
    if (sda3_r.dz) begin
      st_nxt = ST_ZERO_DEN;
    end else if (cclamp || sda3_r.lux_clamp) begin
      st_nxt = ST_CLAMP;
    end else begin
      st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r      <= p_nxt;
      x2_r     <= x2_nxt;
      y2_r     <= y2_nxt;
      z2_r     <= z2_nxt;
      s3_r     <= s3_nxt;
      x3_r     <= x2_r;
      y3_r     <= y2_r;
      lux3_r   <= lux3_nxt;
      lc3_r    <= lc3_nxt;
      num4_r   <= num4_nxt;
      den4_r   <= den4_nxt;
      lux4_r   <= lux3_r;
      lc4_r    <= lc3_r;
      an5_r    <= an5_nxt;
      ad5_r    <= ad5_nxt;
      sd5_r    <= sd5_nxt;
      rem_r[0] <= REM_W'(an5_r);
      dv_r[0]  <= {ad5_r, 2'b00};
      q_r[0]   <= '0;
      sdd_r[0] <= sd6_nxt;
      n_r      <= n_nxt;
      sdn_r    <= sdd_r[Q_W];
      pm1_r    <= pm1_nxt;
      nm1_r    <= n_r;
      sdm1_r   <= sdn_r;
      a1_r     <= a1_nxt;
      na1_r    <= nm1_r;
      sda1_r   <= sdm1_r;
      pm2_r    <= pm2_nxt;
      nm2_r    <= na1_r;
      sdm2_r   <= sda1_r;
      a2_r     <= a2_nxt;
      na2_r    <= nm2_r;
      sda2_r   <= sdm2_r;
      pm3_r    <= pm3_nxt;
      sdm3_r   <= sda2_r;
      a3_r     <= a3_nxt;
      sda3_r   <= sdm3_r;
      cct_r    <= cct_nxt;
      lux_r    <= sda3_r.lux;
      st_r     <= st_nxt;
    end
  end

  assign out_valid      = vld_r[NSTAGE-1];
  assign out_cct_kelvin = cct_r;
  assign out_lux        = lux_r;
  assign out_status     = st_r;

endmodule

`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

module tb_top
  import rgbcct_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct {
    logic [15:0] cct;
    logic [15:0] lux;
    status_t     status;
  } light_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_red;
  logic [15:0] in_green;
  logic [15:0] in_blue;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_cct_kelvin;
  logic [15:0] out_lux;
  logic [1:0]  out_status;

  light_t light_q[$];
  int     mismatch_cnt;
  int     idle_cycles;
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     timed_out;

  rgb_color_temperature_and_lux u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cct_kelvin (out_cct_kelvin),
    .out_lux        (out_lux),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor division by 2^sh for signed values
  function automatic longint floor_div(longint v, int sh);
    longint m;
    if (v >= 0) begin
      return v >>> sh;
    end
    m = -v;
    return -((m + ((64'sd1 <<< sh) - 1)) >>> sh);
  endfunction

  function automatic light_t predict_light(logic [15:0] r16, logic [15:0] g16,
                                           logic [15:0] b16);
    longint r, g, b, x, y, z, s, num, den, luxv, acc, n;
    longint unsigned an, ad, q, rem;
    bit neg, clamped;
    light_t res;
    r = r16;
    g = g16;
    b = b16;
    x = MXR * r + MXG * g + MXB * b;
    y = MYR * r + MYG * g + MYB * b;
    z = MZR * r + MZG * g + MZB * b;
    s = x + y + z;
    num = x * 16384 - longint'(K_0332) * s;
    den = longint'(K_01858) * s - y * 16384;
    luxv = y / 16384;
    clamped = 1'b0;
    res.cct = '0;
    res.status = ST_OK;
    if (luxv < 0) begin
      res.lux = 16'd0;
      clamped = 1'b1;
    end else if (luxv > 65535) begin
      res.lux = 16'hFFFF;
      clamped = 1'b1;
    end else begin
      res.lux = luxv[15:0];
    end
    if (den == 0) begin
      res.status = ST_ZERO_DEN;
    end else begin
      neg = (num < 0) != (den < 0);
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q = an / ad;
      if (q >= 8 && an != 0) begin
        res.cct = neg ? 16'd0 : 16'hFFFF;
        clamped = 1'b1;
      end else begin
        rem = an - q * ad;
        for (int i = 0; i < FRAC_BITS; i++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= ad) begin
            rem = rem - ad;
            q = q | 1;
          end
        end
        n = neg ? -longint'(q) : longint'(q);
        acc = CUB3;
        acc = floor_div(acc * n, FRAC_BITS) + CUB2;
        acc = floor_div(acc * n, FRAC_BITS) + CUB1;
        acc = floor_div(acc * n, FRAC_BITS) + CUB0;
        acc = floor_div(acc, 14);
        if (acc < 0) begin
          res.cct = 16'd0;
          clamped = 1'b1;
        end else if (acc > 65535) begin
          res.cct = 16'hFFFF;
          clamped = 1'b1;
        end else begin
          res.cct = acc[15:0];
        end
      end
    end
    if (res.status == ST_OK && clamped) begin
      res.status = ST_CLAMP;
    end
    return res;
  endfunction

  // valid stays high between back-to-back requests; it drops only while idling
  task automatic send_sample(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do begin
      @(posedge clk);
    end while (!in_ready);
    light_q.push_back(predict_light(r, g, b));
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    light_t want;
    if (rst_n && out_valid && out_ready) begin
      if (light_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected result cct=%0d lux=%0d status=%0d",
                   out_cct_kelvin, out_lux, out_status);
        end
      end else begin
        want = light_q.pop_front();
        if (out_cct_kelvin !== want.cct || out_lux !== want.lux ||
            out_status !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: exp cct=%0d lux=%0d status=%0d",
                     want.cct, want.lux, want.status);
            $display("          got cct=%0d lux=%0d status=%0d",
                     out_cct_kelvin, out_lux, out_status);
          end
        end
      end
    end
  end

  // watchdog: cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
      end
    end
  end

  initial begin
    @(posedge clk);
    wait (timed_out);
    $display("status: fail");
    $finish;
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_sample(16'd0, 16'd0, 16'd0);          // zero denominator
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'hFFFF, 16'd0, 16'd0);       // negative lux
    send_sample(16'd0, 16'hFFFF, 16'd0);       // lux clamp high
    send_sample(16'd0, 16'd0, 16'hFFFF);
    send_sample(16'hFFFF, 16'hFFFF, 16'd0);
    send_sample(16'd0, 16'hFFFF, 16'hFFFF);
    send_sample(16'hFFFF, 16'd0, 16'hFFFF);
    send_sample(16'd1, 16'd0, 16'd0);
    send_sample(16'd0, 16'd1, 16'd0);
    send_sample(16'd0, 16'd0, 16'd1);
    send_sample(16'd1000, 16'd1000, 16'd1000);
    send_sample(16'd2000, 16'd3000, 16'd1500);
    send_sample(16'd3000, 16'd2000, 16'd800);
    send_sample(16'd800, 16'd2000, 16'd3000);
    send_sample(16'd5000, 16'd4000, 16'd1000);
    send_sample(16'd100, 16'd120, 16'd90);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h5555, 16'hAAAA);
    send_sample(16'd40, 16'd60, 16'd20);
  endtask

  task automatic test_random(int count, int send_pct, int recv_pct);
    logic [15:0] r, g, b;
    set_idling(send_pct, recv_pct);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: begin
          r = 16'($urandom);
          g = 16'($urandom);
          b = 16'($urandom);
        end
        1: begin
          // roughly balanced light, lands inside the cubic's range
          g = 16'($urandom_range(60000, 10));
          r = 16'((g * $urandom_range(150, 50)) / 100);
          b = 16'((g * $urandom_range(150, 30)) / 100);
        end
        2: begin
          r = 16'($urandom_range(255));
          g = 16'($urandom_range(255));
          b = 16'($urandom_range(255));
        end
        default: begin
          g = 16'($urandom_range(4000));
          r = 16'(g + $urandom_range(40) - 20);
          b = 16'(g + $urandom_range(40) - 20);
        end
      endcase
      send_sample(r, g, b);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    out_ready = 1'b0;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    timed_out    = 1'b0;
    set_idling(0, 0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(130, 0, 0);
    test_random(130, 62, 0);
    test_random(130, 0, 62);
    test_random(120, 33, 33);
    test_random(20, 0, 0);
    in_valid <= 1'b0;

    set_idling(0, 20);
    while (light_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && light_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
